FILE: rtl/core/stacked_fm_oscillator_defines.svh
// ----------------------------------------------------------------------------
// Stacked FM oscillator assertion macros
// Concurrent assertion helpers used by the oscillator controller.
// ----------------------------------------------------------------------------
`ifndef STACKED_FM_OSCILLATOR_DEFINES_SVH
`define STACKED_FM_OSCILLATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define SFM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define SFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SFM_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define SFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/core/sfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stacked FM oscillator package
// Shared constants, register indexes and controller command types.
// ----------------------------------------------------------------------------
package sfm_pkg;

   localparam int SFM_PHASE_BITS  = 32;
   localparam int SFM_TABLE_BITS  = 10;
   localparam int SFM_SAMPLE_BITS = 16;

   localparam int FREQ_BITS       = 32;
   localparam int INDEX_BITS      = 16;
   localparam int INDEX_FRAC_BITS = 8;
   localparam int AMP_BITS        = 15;
   localparam int OUT_BITS        = 16;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_CARRIER_AMPLITUDE = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CARRIER_FREQ      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MOD0_FREQ         = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MOD1_OFFSET_FREQ  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MOD0_INDEX        = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MOD1_INDEX        = 3'd5;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_MUL_AMP0,
      OP_AMP_WB,
      OP_MUL_OUT0,
      OP_SUM0,
      OP_MUL_AMP1,
      OP_MUL_OUT1,
      OP_SUM1,
      OP_MUL_SMP,
      OP_SMP_WB
   } op_type;

   typedef enum logic [1:0] {
      ROM_MOD0,
      ROM_MOD1,
      ROM_CARRIER
   } rom_sel_type;

   typedef struct packed {
      op_type      op;
      logic        rom_rd;
      rom_sel_type rom_sel;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/core/stacked_fm_oscillator.sv
// A sample is valid once its accepted tick has run ten sequencing steps around
// five products through one multiplier; the last step waits while a result is
// still held unaccepted. No new tick is accepted until the sequence is done.
// A cleared tick is accepted and produces no transaction.
// Synchronous active-high reset clears phases, config registers and output valid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stacked FM oscillator
// Three-operator cascaded FM cosine oscillator with streaming ports.
// ----------------------------------------------------------------------------
module stacked_fm_oscillator import sfm_pkg::*; #(
   parameter int PHASE_BITS  = SFM_PHASE_BITS,
   parameter int TABLE_BITS  = SFM_TABLE_BITS,
   parameter int SAMPLE_BITS = SFM_SAMPLE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [0] tick
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [OUT_BITS-1:0]            rsp_tdata,   // [15:0] sample
   input  wire logic                      csr_wen,
   input  wire logic [CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cmd_type cmd;

   sfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tick   (req_tdata[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sfm_datapath #(
      .PHASE_BITS  (PHASE_BITS),
      .TABLE_BITS  (TABLE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sample    (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: rtl/core/sfm_cos_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stacked FM oscillator cosine table
// Quarter-wave cosine table with registered read and quadrant folding.
// ----------------------------------------------------------------------------
module sfm_cos_rom import sfm_pkg::*; #(
   parameter int PHASE_BITS  = SFM_PHASE_BITS,
   parameter int TABLE_BITS  = SFM_TABLE_BITS,
   parameter int SAMPLE_BITS = SFM_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          rd_en,
   input  wire logic [PHASE_BITS-1:0]         phase,
   output logic signed [SAMPLE_BITS-1:0]      cos_value
);

   localparam int QTR_SIZE  = 1 << TABLE_BITS;
   localparam int COS_SHIFT = SAMPLE_BITS - 1;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam logic [TABLE_BITS:0] QTR_LAST = {1'b1, {TABLE_BITS{1'b0}}};

   typedef logic [SAMPLE_BITS-2:0] entry_type;
   typedef entry_type tab_type [0:QTR_SIZE];

   // Shift-and-subtract quotient, evaluated only while the table is built.
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned dvs);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= dvs) begin
            rem    = rem - dvs;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic tab_type build_tab();
      tab_type         t;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned den;
      longint          sum;
      longint          r;
      longint          cap;
      for (int j = 0; j <= QTR_SIZE; j++) begin
         x    = (HALF_PI_Q30 * longint'(j)) >> TABLE_BITS;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = longint'(term);
         for (int k = 1; k <= 10; k++) begin
            den  = longint'((2 * k - 1) * (2 * k));
            term = (term * x2) >> 30;
            term = div_u64(term, den);
            if ((k & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         cap = (longint'(1) << COS_SHIFT) - 1;
         r   = (sum + (longint'(1) << (30 - COS_SHIFT - 1))) >>> (30 - COS_SHIFT);
         if (r > cap) begin
            r = cap;
         end
         t[j] = r[SAMPLE_BITS-2:0];
      end
      return t;
   endfunction

   localparam tab_type QTR_TAB = build_tab();

   logic [TABLE_BITS+1:0] point;
   logic [1:0]            quadrant;
   logic [TABLE_BITS:0]   fine;
   logic [TABLE_BITS:0]   rom_addr;
   entry_type             rom_q_ff;
   logic                  neg_ff;
   logic signed [SAMPLE_BITS-1:0] mag;

   assign point    = phase[PHASE_BITS-1 -: TABLE_BITS+2];
   assign quadrant = point[TABLE_BITS+1:TABLE_BITS];
   assign fine     = {1'b0, point[TABLE_BITS-1:0]};
   assign rom_addr = quadrant[0] ? (QTR_LAST - fine) : fine;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rom_q_ff <= QTR_TAB[rom_addr];
         neg_ff   <= quadrant[1] ^ quadrant[0];
      end
   end

   assign mag       = signed'({1'b0, rom_q_ff});
   assign cos_value = neg_ff ? -mag : mag;

endmodule
`default_nettype wire

FILE: rtl/core/sfm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stacked FM oscillator datapath
// Configuration registers, phase accumulators and one shared multiplier.
// ----------------------------------------------------------------------------
module sfm_datapath import sfm_pkg::*; #(
   parameter int PHASE_BITS  = SFM_PHASE_BITS,
   parameter int TABLE_BITS  = SFM_TABLE_BITS,
   parameter int SAMPLE_BITS = SFM_SAMPLE_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wen,
   input  wire logic [CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire cmd_type                    cmd,
   output logic [OUT_BITS-1:0]             sample
);

   localparam int COS_SHIFT = SAMPLE_BITS - 1;
   localparam int MUL_B_BITS = (SAMPLE_BITS > INDEX_BITS + 1) ? SAMPLE_BITS : INDEX_BITS + 1;
   localparam int PROD_BITS = FREQ_BITS + MUL_B_BITS;

   localparam logic signed [FREQ_BITS-1:0] FREQ_MAX = {1'b0, {(FREQ_BITS-1){1'b1}}};
   localparam logic signed [FREQ_BITS-1:0] FREQ_MIN = {1'b1, {(FREQ_BITS-1){1'b0}}};

   logic [AMP_BITS-1:0]          carrier_amplitude_ff;
   logic signed [FREQ_BITS-1:0]  carrier_freq_ff;
   logic signed [FREQ_BITS-1:0]  mod0_freq_ff;
   logic signed [FREQ_BITS-1:0]  mod1_offset_freq_ff;
   logic [INDEX_BITS-1:0]        mod0_index_ff;
   logic [INDEX_BITS-1:0]        mod1_index_ff;

   logic [PHASE_BITS-1:0]        mod0_phase_ff;
   logic [PHASE_BITS-1:0]        mod1_phase_ff;
   logic [PHASE_BITS-1:0]        carrier_phase_ff;

   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [FREQ_BITS-1:0]  amp_ff;
   logic signed [FREQ_BITS-1:0]  sum_ff;
   logic [OUT_BITS-1:0]          sample_ff;

   logic [PHASE_BITS-1:0]        rom_phase;
   logic signed [SAMPLE_BITS-1:0] cos_value;
   logic signed [FREQ_BITS-1:0]  mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  amp_shift;
   logic signed [PROD_BITS-1:0]  osc_shift;
   logic [PROD_BITS-32:0]        amp_high;
   logic signed [FREQ_BITS-1:0]  amp_sat;
   logic signed [FREQ_BITS-1:0]  sum_base;
   logic signed [FREQ_BITS:0]    sum_wide;
   logic signed [FREQ_BITS-1:0]  sum_sat;
   logic                         is_mul;

   function automatic logic [PHASE_BITS-1:0] ext_inc(input logic signed [FREQ_BITS-1:0] f);
      logic signed [63:0] w;
      w = 64'(f);
      return w[PHASE_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_amplitude_ff <= '0;
         carrier_freq_ff      <= '0;
         mod0_freq_ff         <= '0;
         mod1_offset_freq_ff  <= '0;
         mod0_index_ff        <= '0;
         mod1_index_ff        <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_CARRIER_AMPLITUDE: carrier_amplitude_ff <= csr_wdata[AMP_BITS-1:0];
            CSR_CARRIER_FREQ:      carrier_freq_ff      <= signed'(csr_wdata);
            CSR_MOD0_FREQ:         mod0_freq_ff         <= signed'(csr_wdata);
            CSR_MOD1_OFFSET_FREQ:  mod1_offset_freq_ff  <= signed'(csr_wdata);
            CSR_MOD0_INDEX:        mod0_index_ff        <= csr_wdata[INDEX_BITS-1:0];
            CSR_MOD1_INDEX:        mod1_index_ff        <= csr_wdata[INDEX_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.rom_sel)
         ROM_MOD0:    rom_phase = mod0_phase_ff;
         ROM_MOD1:    rom_phase = mod1_phase_ff;
         ROM_CARRIER: rom_phase = carrier_phase_ff;
         default:     rom_phase = carrier_phase_ff;
      endcase
   end

   sfm_cos_rom #(
      .PHASE_BITS  (PHASE_BITS),
      .TABLE_BITS  (TABLE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_cos_rom (
      .clock     (clock),
      .rd_en     (cmd.rom_rd),
      .phase     (rom_phase),
      .cos_value (cos_value)
   );

   always_comb begin
      is_mul = 1'b1;
      mul_a  = mod0_freq_ff;
      mul_b  = MUL_B_BITS'(cos_value);
      case (cmd.op) inside
         OP_MUL_AMP0: begin
            mul_a = mod0_freq_ff;
            mul_b = signed'(MUL_B_BITS'(mod0_index_ff));
         end
         OP_MUL_AMP1: begin
            mul_a = sum_ff;
            mul_b = signed'(MUL_B_BITS'(mod1_index_ff));
         end
         OP_MUL_OUT0, OP_MUL_OUT1: begin
            mul_a = amp_ff;
            mul_b = MUL_B_BITS'(cos_value);
         end
         OP_MUL_SMP: begin
            mul_a = signed'(FREQ_BITS'(carrier_amplitude_ff));
            mul_b = MUL_B_BITS'(cos_value);
         end
         default: is_mul = 1'b0;
      endcase
   end

   assign amp_shift = prod_ff >>> INDEX_FRAC_BITS;
   assign osc_shift = prod_ff >>> COS_SHIFT;
   assign amp_high  = amp_shift[PROD_BITS-1:FREQ_BITS-1];

   always_comb begin
      if ((&amp_high) || !(|amp_high)) begin
         amp_sat = amp_shift[FREQ_BITS-1:0];
      end else begin
         amp_sat = amp_shift[PROD_BITS-1] ? FREQ_MIN : FREQ_MAX;
      end
   end

   assign sum_base = (cmd.op == OP_SUM0) ? mod1_offset_freq_ff : carrier_freq_ff;
   assign sum_wide = {osc_shift[FREQ_BITS-1], osc_shift[FREQ_BITS-1:0]}
                   + {sum_base[FREQ_BITS-1], sum_base};

   always_comb begin
      if (sum_wide[FREQ_BITS] != sum_wide[FREQ_BITS-1]) begin
         sum_sat = sum_wide[FREQ_BITS] ? FREQ_MIN : FREQ_MAX;
      end else begin
         sum_sat = sum_wide[FREQ_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (is_mul) begin
         prod_ff <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      end
      if (cmd.op == OP_AMP_WB) begin
         amp_ff <= amp_sat;
      end
      if (cmd.op == OP_SUM0 || cmd.op == OP_SUM1) begin
         sum_ff <= sum_sat;
      end
      if (cmd.op == OP_SMP_WB) begin
         sample_ff <= osc_shift[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod0_phase_ff    <= '0;
         mod1_phase_ff    <= '0;
         carrier_phase_ff <= '0;
      end else begin
         if (cmd.op == OP_SUM0) begin
            mod0_phase_ff <= mod0_phase_ff + ext_inc(mod0_freq_ff);
         end
         if (cmd.op == OP_MUL_OUT1) begin
            mod1_phase_ff <= mod1_phase_ff + ext_inc(sum_ff);
         end
         if (cmd.op == OP_SMP_WB) begin
            carrier_phase_ff <= carrier_phase_ff + ext_inc(sum_ff);
         end
      end
   end

   assign sample = sample_ff;

endmodule
`default_nettype wire

FILE: rtl/core/sfm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stacked FM oscillator controller
// Sequences the shared multiplier, table reads and the output register.
// ----------------------------------------------------------------------------
`include "stacked_fm_oscillator_defines.svh"

module sfm_ctrl import sfm_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   input  wire logic  req_tick,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AMP0,
      ST_AMP0_WB,
      ST_OUT0,
      ST_SUM0,
      ST_AMP1,
      ST_AMP1_WB,
      ST_OUT1,
      ST_SUM1,
      ST_SMP,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_tvalid_ff;
   logic      out_free;
   logic      accept;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '{op: OP_NONE, rom_rd: 1'b0, rom_sel: ROM_MOD0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tick) begin
               state_in = ST_AMP0;
            end
         end
         ST_AMP0: begin
            cmd      = '{op: OP_MUL_AMP0, rom_rd: 1'b1, rom_sel: ROM_MOD0};
            state_in = ST_AMP0_WB;
         end
         ST_AMP0_WB: begin
            cmd.op   = OP_AMP_WB;
            state_in = ST_OUT0;
         end
         ST_OUT0: begin
            cmd.op   = OP_MUL_OUT0;
            state_in = ST_SUM0;
         end
         ST_SUM0: begin
            cmd      = '{op: OP_SUM0, rom_rd: 1'b1, rom_sel: ROM_MOD1};
            state_in = ST_AMP1;
         end
         ST_AMP1: begin
            cmd.op   = OP_MUL_AMP1;
            state_in = ST_AMP1_WB;
         end
         ST_AMP1_WB: begin
            cmd.op   = OP_AMP_WB;
            state_in = ST_OUT1;
         end
         ST_OUT1: begin
            cmd.op   = OP_MUL_OUT1;
            state_in = ST_SUM1;
         end
         ST_SUM1: begin
            cmd      = '{op: OP_SUM1, rom_rd: 1'b1, rom_sel: ROM_CARRIER};
            state_in = ST_SMP;
         end
         ST_SMP: begin
            cmd.op   = OP_MUL_SMP;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.op   = OP_SMP_WB;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   `SFM_ASSERT_NEXT(a_tick_starts, clock, reset, accept && req_tick, state_ff == ST_AMP0,
      "Accepted tick did not start the sample sequence.")
   `SFM_ASSERT_NEXT(a_idle_tick_ignored, clock, reset, accept && !req_tick,
      state_ff == ST_IDLE && (!rsp_tvalid_ff || $past(rsp_tvalid_ff)),
      "Cleared tick produced work or a result.")
   `SFM_ASSERT_NEXT(a_result_loaded, clock, reset, state_ff == ST_DONE && out_free,
      rsp_tvalid_ff && state_ff == ST_IDLE, "Finished sample was not presented.")
   `SFM_ASSERT_NEXT(a_no_overwrite, clock, reset, state_ff == ST_DONE && !out_free,
      state_ff == ST_DONE && rsp_tvalid_ff, "Pending result was overwritten.")

endmodule
`default_nettype wire
